// File: src/bsb_pkg.sv
// ----------------------------------------------------------------------------
// bsb_pkg: shared constants and types for the brush stamp pixel blend
// Widths, reset values, register indexes and the pipeline control bundle.
// ----------------------------------------------------------------------------
package bsb_pkg;

	// coordinate width of the stamp pixel position (8 to 16)
	localparam int CoordBits = 14;
	// image dimension register width
	localparam int DimBits   = 13;
	// width used for the bounds compare
	localparam int CmpBits   = (CoordBits > DimBits) ? CoordBits : DimBits;

	localparam int ColBits    = 8;
	localparam int PressBits  = 17;
	localparam int WeightBits = 24;
	localparam int ProdBits   = 33;
	localparam int SumBits    = 16;
	localparam int RecipBits  = 16;
	localparam int RecipShift = 23;
	localparam int IdxBits    = 3;
	localparam int CfgBits    = DimBits;

	// pressure of one in Q1.16
	localparam logic [PressBits-1:0] PressOne = 17'h10000;
	// ceil(2^23 / 255): exact floor division by 255 for values below 66052
	localparam logic [RecipBits-1:0] Recip255 = 16'd32897;
	localparam logic [DimBits-1:0]   DimReset = 13'd1024;

	typedef enum logic [IdxBits-1:0] {
		RegBrushRed    = 3'd0,
		RegBrushGreen  = 3'd1,
		RegBrushBlue   = 3'd2,
		RegImageWidth  = 3'd3,
		RegImageHeight = 3'd4,
		RegPixelFormat = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		FmtRgb24   = 1'b0,
		FmtDepth32 = 1'b1
	} pix_fmt_t;

	typedef struct packed {
		logic [ColBits-1:0] brush_red;
		logic [ColBits-1:0] brush_green;
		logic [ColBits-1:0] brush_blue;
		logic [DimBits-1:0] image_width;
		logic [DimBits-1:0] image_height;
		pix_fmt_t           pixel_format;
	} cfg_t;

	// stage load enables for the colour channel pipes
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

// File: src/bsb_cfg.sv
// ----------------------------------------------------------------------------
// bsb_cfg: configuration register file
// Holds paint colour, image size and pixel format; written by index.
// ----------------------------------------------------------------------------
module bsb_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bsb_pkg::IdxBits-1:0]       cfg_index,
	input  logic [bsb_pkg::CfgBits-1:0]       cfg_data,
	output bsb_pkg::cfg_t                     cfg
);

	bsb_pkg::cfg_t cfg_q;

	// write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brush_red    <= '0;
			cfg_q.brush_green  <= '0;
			cfg_q.brush_blue   <= '0;
			cfg_q.image_width  <= bsb_pkg::DimReset;
			cfg_q.image_height <= bsb_pkg::DimReset;
			cfg_q.pixel_format <= bsb_pkg::FmtRgb24;
		end else if (cfg_write) begin
			unique case (bsb_pkg::cfg_reg_t'(cfg_index))
				bsb_pkg::RegBrushRed:    cfg_q.brush_red    <= cfg_data[bsb_pkg::ColBits-1:0];
				bsb_pkg::RegBrushGreen:  cfg_q.brush_green  <= cfg_data[bsb_pkg::ColBits-1:0];
				bsb_pkg::RegBrushBlue:   cfg_q.brush_blue   <= cfg_data[bsb_pkg::ColBits-1:0];
				bsb_pkg::RegImageWidth:  cfg_q.image_width  <= cfg_data[bsb_pkg::DimBits-1:0];
				bsb_pkg::RegImageHeight: cfg_q.image_height <= cfg_data[bsb_pkg::DimBits-1:0];
				bsb_pkg::RegPixelFormat: cfg_q.pixel_format <= bsb_pkg::pix_fmt_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/bsb_chan.sv
// ----------------------------------------------------------------------------
// bsb_chan: one colour channel of the blend, stages 3 to 5
// old + floor((brush - old) * W / (255 * 2^16)), via shift and reciprocal.
// ----------------------------------------------------------------------------
module bsb_chan (
	input  logic                                 clk,
	input  bsb_pkg::pipe_en_t                    en,
	input  logic signed [bsb_pkg::ColBits:0]     diff_s2,
	input  logic [bsb_pkg::WeightBits-1:0]       w_s2,
	input  logic [bsb_pkg::ColBits-1:0]          old_s2,
	input  logic                                 blend_s4,
	output logic [bsb_pkg::ColBits-1:0]          chan_s5
);

	localparam int FullBits = bsb_pkg::ColBits + 1 + bsb_pkg::WeightBits + 1;
	localparam int ShBits   = bsb_pkg::ProdBits - 16;

	logic signed [FullBits-1:0]              prod_full;
	logic signed [bsb_pkg::ProdBits-1:0]     prod_s3;
	logic [bsb_pkg::ColBits-1:0]             old_s3;
	logic [bsb_pkg::SumBits-1:0]             old_x255;
	logic [ShBits-1:0]                       prod_sh;
	logic [bsb_pkg::SumBits+1:0]             sum;
	logic [bsb_pkg::SumBits-1:0]             y_s4;
	logic [bsb_pkg::ColBits-1:0]             old_s4;
	logic [bsb_pkg::SumBits+bsb_pkg::RecipBits-1:0] quot;

	// weighted colour difference
	assign prod_full = diff_s2 * $signed({1'b0, w_s2});

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= prod_full[bsb_pkg::ProdBits-1:0];
			old_s3  <= old_s2;
		end
	end

	// drop the 2^16 part of the divisor (floor), put the old value back on
	assign old_x255 = {old_s3, 8'h00} - {8'h00, old_s3};
	assign prod_sh  = prod_s3[bsb_pkg::ProdBits-1:16];
	assign sum      = {2'b00, old_x255} + {prod_sh[ShBits-1], prod_sh};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_s4   <= sum[bsb_pkg::SumBits-1:0];
			old_s4 <= old_s3;
		end
	end

	// divide by 255 through the reciprocal
	assign quot = y_s4 * bsb_pkg::Recip255;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			chan_s5 <= blend_s4
				? quot[bsb_pkg::RecipShift +: bsb_pkg::ColBits] : old_s4;
		end
	end

endmodule

// File: src/brush_stamp_pixel_blend_top.sv
// ----------------------------------------------------------------------------
// brush_stamp_pixel_blend_top: brush stamp pixel blend
// Depth-tested, pressure-weighted paint of one image pixel per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one stamp pixel per word:
//   coordinates, pattern level, stored depth, mask, old RGB and pressure.
//   Output channel (out_valid / out_stall) returns one word per input word
//   with the colour and depth to write back and a painted flag.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   write it only while no word is in flight.
//   One word per cycle is accepted while in_stall is low; five register
//   stages run in a row: decode, weight multiply, channel multiply,
//   floor sum, reciprocal multiply into the output stage.
//   Each stage loads when it is empty or the next one loads, so bubbles
//   close up while the receiver stalls; in_stall rises only when all five
//   stages hold words and out_stall is high. Nothing is lost or repeated.
//   Reset clears all stage valid bits and sets the registers to black
//   paint, a 1024 x 1024 image and 24-bit mode.
// ----------------------------------------------------------------------------
module brush_stamp_pixel_blend_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [bsb_pkg::IdxBits-1:0]            cfg_index,
	input  logic [bsb_pkg::CfgBits-1:0]            cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [bsb_pkg::CoordBits-1:0]   pixel_col,
	input  logic signed [bsb_pkg::CoordBits-1:0]   pixel_row,
	input  logic [bsb_pkg::ColBits-1:0]            pattern_level,
	input  logic [bsb_pkg::ColBits-1:0]            depth_in,
	input  logic                                   mask_set,
	input  logic [bsb_pkg::ColBits-1:0]            old_red,
	input  logic [bsb_pkg::ColBits-1:0]            old_green,
	input  logic [bsb_pkg::ColBits-1:0]            old_blue,
	input  logic [bsb_pkg::PressBits-1:0]          stroke_pressure,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [bsb_pkg::ColBits-1:0]            new_red,
	output logic [bsb_pkg::ColBits-1:0]            new_green,
	output logic [bsb_pkg::ColBits-1:0]            new_blue,
	output logic [bsb_pkg::ColBits-1:0]            depth_out,
	output logic                                   was_painted
);

	localparam int Cb = bsb_pkg::ColBits;

	bsb_pkg::cfg_t     cfg;
	bsb_pkg::pipe_en_t chan_en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic                           col_in, row_in, paint_d;
	logic [bsb_pkg::PressBits-1:0]  press_d;

	logic                           paint_s1, blend_s1;
	logic [Cb-1:0]                  depth_s1, dz_s1;
	logic [bsb_pkg::PressBits-1:0]  press_s1;
	logic signed [Cb:0]             diff_r_s1, diff_g_s1, diff_b_s1;
	logic [Cb-1:0]                  old_r_s1, old_g_s1, old_b_s1;

	logic [bsb_pkg::PressBits+Cb-1:0] w_full;
	logic [bsb_pkg::WeightBits-1:0]   w_s2;
	logic                             paint_s2, blend_s2;
	logic [Cb-1:0]                    depth_s2;
	logic signed [Cb:0]               diff_r_s2, diff_g_s2, diff_b_s2;
	logic [Cb-1:0]                    old_r_s2, old_g_s2, old_b_s2;

	logic          paint_s3, blend_s3, paint_s4, blend_s4, paint_s5;
	logic [Cb-1:0] depth_s3, depth_s4, depth_s5;

	bsb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage enables: load when empty or when the next stage loads
	assign en_s5 = !valid_s5 || !out_stall;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	assign chan_en.s3 = en_s3;
	assign chan_en.s4 = en_s4;
	assign chan_en.s5 = en_s5;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// bounds, mask and depth test; negative coordinates are outside
	assign col_in = !pixel_col[bsb_pkg::CoordBits-1] &&
		(bsb_pkg::CmpBits'(unsigned'(pixel_col)) < bsb_pkg::CmpBits'(cfg.image_width));
	assign row_in = !pixel_row[bsb_pkg::CoordBits-1] &&
		(bsb_pkg::CmpBits'(unsigned'(pixel_row)) < bsb_pkg::CmpBits'(cfg.image_height));
	assign paint_d = col_in && row_in && mask_set && (pattern_level > depth_in);

	// saturate pressure to one
	assign press_d = (stroke_pressure > bsb_pkg::PressOne) ? bsb_pkg::PressOne
		: stroke_pressure;

	// stage 1: decode the pixel
	always_ff @(posedge clk) begin
		if (en_s1) begin
			paint_s1  <= paint_d;
			blend_s1  <= paint_d && (cfg.pixel_format == bsb_pkg::FmtRgb24);
			depth_s1  <= paint_d ? pattern_level : depth_in;
			dz_s1     <= pattern_level - depth_in;
			press_s1  <= press_d;
			diff_r_s1 <= $signed({1'b0, cfg.brush_red})   - $signed({1'b0, old_red});
			diff_g_s1 <= $signed({1'b0, cfg.brush_green}) - $signed({1'b0, old_green});
			diff_b_s1 <= $signed({1'b0, cfg.brush_blue})  - $signed({1'b0, old_blue});
			old_r_s1  <= old_red;
			old_g_s1  <= old_green;
			old_b_s1  <= old_blue;
		end
	end

	// stage 2: blend weight, at most 255 * 2^16
	assign w_full = press_s1 * dz_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			w_s2      <= w_full[bsb_pkg::WeightBits-1:0];
			paint_s2  <= paint_s1;
			blend_s2  <= blend_s1;
			depth_s2  <= depth_s1;
			diff_r_s2 <= diff_r_s1;
			diff_g_s2 <= diff_g_s1;
			diff_b_s2 <= diff_b_s1;
			old_r_s2  <= old_r_s1;
			old_g_s2  <= old_g_s1;
			old_b_s2  <= old_b_s1;
		end
	end

	// carry flags and depth alongside the channel pipes
	always_ff @(posedge clk) begin
		if (en_s3) begin
			paint_s3 <= paint_s2;
			blend_s3 <= blend_s2;
			depth_s3 <= depth_s2;
		end
		if (en_s4) begin
			paint_s4 <= paint_s3;
			blend_s4 <= blend_s3;
			depth_s4 <= depth_s3;
		end
		if (en_s5) begin
			paint_s5 <= paint_s4;
			depth_s5 <= depth_s4;
		end
	end

	bsb_chan u_chan_red (
		.clk      (clk),
		.en       (chan_en),
		.diff_s2  (diff_r_s2),
		.w_s2     (w_s2),
		.old_s2   (old_r_s2),
		.blend_s4 (blend_s4),
		.chan_s5  (new_red)
	);

	bsb_chan u_chan_green (
		.clk      (clk),
		.en       (chan_en),
		.diff_s2  (diff_g_s2),
		.w_s2     (w_s2),
		.old_s2   (old_g_s2),
		.blend_s4 (blend_s4),
		.chan_s5  (new_green)
	);

	bsb_chan u_chan_blue (
		.clk      (clk),
		.en       (chan_en),
		.diff_s2  (diff_b_s2),
		.w_s2     (w_s2),
		.old_s2   (old_b_s2),
		.blend_s4 (blend_s4),
		.chan_s5  (new_blue)
	);

	assign out_valid   = valid_s5;
	assign depth_out   = depth_s5;
	assign was_painted = paint_s5;

endmodule

// File: src/bsb_checker.sv
// ----------------------------------------------------------------------------
// bsb_checker: port-level checks for the brush stamp pixel blend
// Watches the top level's channels and is bound to it below.
// ----------------------------------------------------------------------------
module bsb_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_stall,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic [bsb_pkg::ColBits-1:0]            new_red,
	input  logic [bsb_pkg::ColBits-1:0]            new_green,
	input  logic [bsb_pkg::ColBits-1:0]            new_blue,
	input  logic [bsb_pkg::ColBits-1:0]            depth_out,
	input  logic                                   was_painted
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_red) && $stable(new_green)
			&& $stable(new_blue) && $stable(depth_out) && $stable(was_painted))
		else $error("stalled output word changed");

	// the input side only backs up behind a stalled output word
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a painted pixel takes a level above some depth, so never zero
	a_paint_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_painted |-> depth_out != '0)
		else $error("painted pixel with zero depth");

	// reset empties the pipe
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("output valid straight after reset");

endmodule

bind brush_stamp_pixel_blend_top bsb_checker u_bsb_checker (.*);

// File: verif/brush_stamp_pixel_blend_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brush_stamp_pixel_blend_checker: write-back predictor and scoreboard
// Tracks the register writes and works out the colour and depth write-back
// for every accepted stamp pixel. Compares each accepted output word field by
// field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module brush_stamp_pixel_blend_checker
	import bsb_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [IdxBits-1:0]          cfg_index,
	input  logic [CfgBits-1:0]          cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic signed [CoordBits-1:0] pixel_col,
	input  logic signed [CoordBits-1:0] pixel_row,
	input  logic [ColBits-1:0]          pattern_level,
	input  logic [ColBits-1:0]          depth_in,
	input  logic                        mask_set,
	input  logic [ColBits-1:0]          old_red,
	input  logic [ColBits-1:0]          old_green,
	input  logic [ColBits-1:0]          old_blue,
	input  logic [PressBits-1:0]        stroke_pressure,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [ColBits-1:0]          new_red,
	input  logic [ColBits-1:0]          new_green,
	input  logic [ColBits-1:0]          new_blue,
	input  logic [ColBits-1:0]          depth_out,
	input  logic                        was_painted,
	output int                          fail_count,
	output int                          words_due,
	output int                          words_checked,
	output int                          words_painted
);

	// full blend weight: pressure of one times the largest level step
	localparam longint unsigned FullWeight = 64'd255 * 64'd65536;

	typedef struct packed {
		logic [ColBits-1:0] red;
		logic [ColBits-1:0] green;
		logic [ColBits-1:0] blue;
		logic [ColBits-1:0] depth;
		logic               painted;
	} writeback_t;

	logic [ColBits-1:0] paint_red;
	logic [ColBits-1:0] paint_green;
	logic [ColBits-1:0] paint_blue;
	logic [DimBits-1:0] img_width;
	logic [DimBits-1:0] img_height;
	pix_fmt_t           img_fmt;

	writeback_t writeback_due[$];
	int         misses;
	int         due_count;
	int         checked;
	int         painted;

	assign fail_count    = misses;
	assign words_due     = due_count;
	assign words_checked = checked;
	assign words_painted = painted;

	// sign bit set or past the limit means off the image
	function automatic bit on_image(input logic signed [CoordBits-1:0] c,
			input logic [DimBits-1:0] lim);
		return !c[CoordBits-1] && ($unsigned(c) < lim);
	endfunction

	// floor of the weighted mix between paint and old colour
	function automatic logic [ColBits-1:0] mix_channel(input logic [ColBits-1:0] paint,
			input logic [ColBits-1:0] old, input longint unsigned weight);
		longint unsigned acc;
		acc = paint * weight + old * (FullWeight - weight);
		return ColBits'(acc / FullWeight);
	endfunction

	function automatic writeback_t paint_pixel(
			input logic signed [CoordBits-1:0] col,
			input logic signed [CoordBits-1:0] row,
			input logic [ColBits-1:0] level,
			input logic [ColBits-1:0] depth,
			input logic mask,
			input logic [ColBits-1:0] red,
			input logic [ColBits-1:0] green,
			input logic [ColBits-1:0] blue,
			input logic [PressBits-1:0] press);
		writeback_t res;
		logic [PressBits-1:0] p;
		longint unsigned weight;
		res.red     = red;
		res.green   = green;
		res.blue    = blue;
		res.depth   = depth;
		res.painted = 1'b0;
		// clamp pressure at one
		p = (press > PressOne) ? PressOne : press;
		if (on_image(col, img_width) && on_image(row, img_height) && mask
				&& level > depth) begin
			res.painted = 1'b1;
			res.depth   = level;
			if (img_fmt == FmtRgb24) begin
				weight    = p * (level - depth);
				res.red   = mix_channel(paint_red, red, weight);
				res.green = mix_channel(paint_green, green, weight);
				res.blue  = mix_channel(paint_blue, blue, weight);
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			misses++;
		end
	endtask

	// track registers, queue predictions, compare output words
	always @(posedge clk or negedge arst_n) begin
		writeback_t due;
		if (!arst_n) begin
			paint_red   = '0;
			paint_green = '0;
			paint_blue  = '0;
			img_width   = DimReset;
			img_height  = DimReset;
			img_fmt     = FmtRgb24;
			writeback_due.delete();
			misses    = 0;
			due_count = 0;
			checked   = 0;
			painted   = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					RegBrushRed:    paint_red   = cfg_data[ColBits-1:0];
					RegBrushGreen:  paint_green = cfg_data[ColBits-1:0];
					RegBrushBlue:   paint_blue  = cfg_data[ColBits-1:0];
					RegImageWidth:  img_width   = cfg_data[DimBits-1:0];
					RegImageHeight: img_height  = cfg_data[DimBits-1:0];
					RegPixelFormat: img_fmt     = pix_fmt_t'(cfg_data[0]);
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				writeback_due.push_back(paint_pixel(pixel_col, pixel_row, pattern_level,
					depth_in, mask_set, old_red, old_green, old_blue, stroke_pressure));
				due_count++;
			end
			if (out_valid && !out_stall) begin
				if (writeback_due.size() == 0) begin
					$error("output word with no prediction due");
					misses++;
				end else begin
					due = writeback_due.pop_front();
					due_count--;
					checked++;
					if (due.painted)
						painted++;
					check_field("new_red", due.red, new_red);
					check_field("new_green", due.green, new_green);
					check_field("new_blue", due.blue, new_blue);
					check_field("depth_out", due.depth, depth_out);
					check_field("was_painted", due.painted, was_painted);
				end
			end
		end
	end

endmodule

// File: verif/brush_stamp_pixel_blend_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brush_stamp_pixel_blend_top_tb: stamp pixel blend testbench
// Drives directed corner pixels and then random stamp pixels through several
// register settings with sender gaps and receiver stalls, one long receiver
// hold-off and a full drain; the checker predicts every write-back word.
// ----------------------------------------------------------------------------
module brush_stamp_pixel_blend_top_tb;
	import bsb_pkg::*;

	localparam int ItemsPerPhase = 226;
	localparam int PhaseCount    = 5;
	localparam int HoldCycles    = 80;
	localparam int DrainCycles   = 8;
	localparam int WatchdogLimit = 2000;
	// indexes past the last register, writes there must change nothing
	localparam logic [IdxBits-1:0] RegSpareLo = 3'd6;
	localparam logic [IdxBits-1:0] RegSpareHi = 3'd7;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [IdxBits-1:0]          cfg_index;
	logic [CfgBits-1:0]          cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic signed [CoordBits-1:0] pixel_col;
	logic signed [CoordBits-1:0] pixel_row;
	logic [ColBits-1:0]          pattern_level;
	logic [ColBits-1:0]          depth_in;
	logic                        mask_set;
	logic [ColBits-1:0]          old_red;
	logic [ColBits-1:0]          old_green;
	logic [ColBits-1:0]          old_blue;
	logic [PressBits-1:0]        stroke_pressure;
	logic                        out_valid;
	logic                        out_stall;
	logic [ColBits-1:0]          new_red;
	logic [ColBits-1:0]          new_green;
	logic [ColBits-1:0]          new_blue;
	logic [ColBits-1:0]          depth_out;
	logic                        was_painted;

	int fail_count;
	int words_due;
	int words_checked;
	int words_painted;

	int                 send_gap_pct = 0;
	int                 stall_pct    = 0;
	int                 hold_asked   = 0;
	int                 pixels_sent  = 0;
	int                 settings_run = 0;
	logic [DimBits-1:0] cur_w        = DimReset;
	logic [DimBits-1:0] cur_h        = DimReset;

	brush_stamp_pixel_blend_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_col      (pixel_col),
		.pixel_row      (pixel_row),
		.pattern_level  (pattern_level),
		.depth_in       (depth_in),
		.mask_set       (mask_set),
		.old_red        (old_red),
		.old_green      (old_green),
		.old_blue       (old_blue),
		.stroke_pressure(stroke_pressure),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.new_red        (new_red),
		.new_green      (new_green),
		.new_blue       (new_blue),
		.depth_out      (depth_out),
		.was_painted    (was_painted)
	);

	brush_stamp_pixel_blend_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_col      (pixel_col),
		.pixel_row      (pixel_row),
		.pattern_level  (pattern_level),
		.depth_in       (depth_in),
		.mask_set       (mask_set),
		.old_red        (old_red),
		.old_green      (old_green),
		.old_blue       (old_blue),
		.stroke_pressure(stroke_pressure),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.new_red        (new_red),
		.new_green      (new_green),
		.new_blue       (new_blue),
		.depth_out      (depth_out),
		.was_painted    (was_painted),
		.fail_count     (fail_count),
		.words_due      (words_due),
		.words_checked  (words_checked),
		.words_painted  (words_painted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one register write per cycle, write enable left high for the caller
	task automatic drive_cfg(input logic [IdxBits-1:0] idx, input logic [CfgBits-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	// write all six registers, then drop the write enable
	task automatic load_setting(input logic [CfgBits-1:0] red, input logic [CfgBits-1:0] green,
			input logic [CfgBits-1:0] blue, input logic [DimBits-1:0] w,
			input logic [DimBits-1:0] h, input pix_fmt_t fmt);
		drive_cfg(RegBrushRed, red);
		drive_cfg(RegBrushGreen, green);
		drive_cfg(RegBrushBlue, blue);
		drive_cfg(RegImageWidth, w);
		drive_cfg(RegImageHeight, h);
		// spare bits above the format bit toggle too
		drive_cfg(RegPixelFormat, {(CfgBits-1)'($urandom), fmt});
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_w = w;
		cur_h = h;
		settings_run++;
	endtask

	// hold the sender until every predicted word has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// offer one stamp pixel and hold it until the block takes it
	task automatic send_pixel(input logic signed [CoordBits-1:0] col,
			input logic signed [CoordBits-1:0] row,
			input logic [ColBits-1:0] level, input logic [ColBits-1:0] depth,
			input logic mask, input logic [ColBits-1:0] red,
			input logic [ColBits-1:0] green, input logic [ColBits-1:0] blue,
			input logic [PressBits-1:0] press);
		bit stalled;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		pixel_col       <= col;
		pixel_row       <= row;
		pattern_level   <= level;
		depth_in        <= depth;
		mask_set        <= mask;
		old_red         <= red;
		old_green       <= green;
		old_blue        <= blue;
		stroke_pressure <= press;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		pixels_sent++;
	endtask

	// mostly on the image, some on the edge, some negative, some anywhere
	function automatic logic [CoordBits-1:0] pick_coord(input logic [DimBits-1:0] lim);
		int k;
		k = $urandom_range(0, 99);
		if (k < 78 && lim != 0)
			return CoordBits'($urandom_range(0, lim - 1));
		if (k < 86)
			return CoordBits'(lim + $urandom_range(0, 1));
		if (k < 92)
			return CoordBits'(-$urandom_range(1, 4));
		return CoordBits'($urandom);
	endfunction

	task automatic send_random_pixel();
		int                   d;
		int                   k;
		logic [ColBits-1:0]   level;
		logic [PressBits-1:0] press;
		d = $urandom_range(0, 255);
		// bias towards a level above the stored depth
		if ($urandom_range(0, 99) < 70)
			level = (d == 255) ? ColBits'(d) : ColBits'($urandom_range(d + 1, 255));
		else
			level = ColBits'($urandom_range(0, d));
		k = $urandom_range(0, 99);
		if (k < 12)
			press = PressOne;
		else if (k < 20)
			press = PressBits'($urandom_range(PressOne + 1, 131071));
		else if (k < 25)
			press = '0;
		else
			press = PressBits'($urandom_range(0, PressOne - 1));
		send_pixel(pick_coord(cur_w), pick_coord(cur_h), level, ColBits'(d),
			$urandom_range(0, 99) < 88, ColBits'($urandom), ColBits'($urandom),
			ColBits'($urandom), press);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int left;
		int seen;
		left = 0;
		seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != seen) begin
				seen = hold_asked;
				left = HoldCycles;
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else
				out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog: end the run when no word moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles, %0d words still due",
			WatchdogLimit, words_due);
		$display("status: fail");
		$finish;
	end

	initial begin
		int phase;
		int n;
		arst_n          <= 1'b0;
		cfg_write       <= 1'b0;
		cfg_index       <= RegBrushRed;
		cfg_data        <= '0;
		in_valid        <= 1'b0;
		pixel_col       <= '0;
		pixel_row       <= '0;
		pattern_level   <= '0;
		depth_in        <= '0;
		mask_set        <= 1'b0;
		old_red         <= '0;
		old_green       <= '0;
		old_blue        <= '0;
		stroke_pressure <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small image, blend corners and bounds
		load_setting(200, 100, 50, 16, 8, FmtRgb24);
		send_pixel(3, 2, 255, 0, 1, 10, 20, 30, PressOne);
		send_pixel(0, 0, 128, 64, 1, 255, 255, 255, 0);
		send_pixel(15, 7, 200, 10, 1, 0, 128, 255, 17'h1FFFF);
		send_pixel(5, 5, 100, 99, 1, 77, 88, 99, PressOne + 1);
		send_pixel(5, 5, 90, 90, 1, 11, 22, 33, PressOne);
		send_pixel(5, 5, 10, 200, 1, 11, 22, 33, PressOne);
		send_pixel(5, 5, 255, 0, 0, 11, 22, 33, PressOne);
		send_pixel(-1, 3, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(-8192, 3, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(8191, 3, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(16, 3, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(3, 8, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(3, -8192, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(3, 8191, 255, 0, 1, 44, 55, 66, PressOne);
		send_pixel(2, 2, 255, 254, 1, 255, 0, 255, 32768);
		send_pixel(1, 1, 1, 0, 1, 0, 0, 0, PressOne - 1);

		// zero width leaves every pixel off the image
		wait_idle();
		load_setting(0, 255, 0, 0, 4096, FmtDepth32);
		send_pixel(0, 0, 255, 0, 1, 1, 2, 3, PressOne);

		// zero height likewise
		wait_idle();
		load_setting(255, 0, 255, 8191, 0, FmtRgb24);
		send_pixel(0, 0, 255, 0, 1, 1, 2, 3, PressOne);

		// depth-only mode on a 4096 x 4096 image
		wait_idle();
		load_setting(255, 255, 255, 4096, 4096, FmtDepth32);
		send_pixel(100, 4095, 200, 50, 1, 1, 2, 3, PressOne);
		send_pixel(4095, 0, 50, 200, 1, 1, 2, 3, PressOne);
		send_pixel(4096, 0, 255, 0, 1, 1, 2, 3, PressOne);
		send_pixel(7, 7, 255, 0, 0, 1, 2, 3, PressOne);

		// random phases, each with its own setting and idling mix
		for (phase = 0; phase < PhaseCount; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					send_gap_pct = 0;
					stall_pct    = 0;
					load_setting(CfgBits'($urandom), CfgBits'($urandom), CfgBits'($urandom),
						4096, 4096, FmtRgb24);
				end
				1: begin
					send_gap_pct = 58;
					stall_pct    = 0;
					load_setting(13'h1FFF, 13'h0FF, 13'h1FFF, 1, 1, FmtRgb24);
				end
				2: begin
					send_gap_pct = 0;
					stall_pct    = 58;
					load_setting(CfgBits'($urandom), CfgBits'($urandom), CfgBits'($urandom),
						DimBits'($urandom_range(1, 4096)), DimBits'($urandom_range(1, 4096)),
						FmtDepth32);
				end
				3: begin
					send_gap_pct = 9;
					stall_pct    = 9;
					load_setting(13'h1F00, 13'h0000, 13'h1F00, 8191, 8191, FmtRgb24);
				end
				default: begin
					send_gap_pct = 0;
					stall_pct    = 0;
					drive_cfg(RegSpareLo, CfgBits'($urandom));
					drive_cfg(RegSpareHi, CfgBits'($urandom));
					load_setting(CfgBits'($urandom), CfgBits'($urandom), CfgBits'($urandom),
						DimBits'($urandom_range(1, 300)), DimBits'($urandom_range(1, 300)),
						FmtRgb24);
					// long receiver hold-off while the sender keeps offering
					hold_asked++;
				end
			endcase
			for (n = 0; n < ItemsPerPhase; n++) begin
				if (phase == 1 && n == ItemsPerPhase / 2)
					wait_idle();
				send_random_pixel();
			end
		end

		wait_idle();
		$display("covered %0d stamp pixels over %0d register settings, gaps, stalls and a hold-off",
			pixels_sent, settings_run);
		$display("checked %0d write-back words, %0d painted, %0d mismatches",
			words_checked, words_painted, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
